// ===== rtl/core/nibble_run_length_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// nibble_run_length_encoder_defines.svh
// Assertion macros for the nibble run-length encoder.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RUN_LENGTH_ENCODER_DEFINES_SVH
`define NIBBLE_RUN_LENGTH_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define NRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define NRLE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define NRLE_ASSERT(lbl, prop, msg)
`define NRLE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/core/nrle_pkg.sv =====
// ----------------------------------------------------------------------------
// nrle_pkg
// Shared types and constants of the nibble run-length encoder.
// ----------------------------------------------------------------------------
package nrle_pkg;

  // Longest run before it is forced to end; length minus two fits a nybble.
  localparam int unsigned MaxRunLen  = 17;
  localparam int unsigned QueueDepth = 2;

  localparam logic KindData  = 1'b0;
  localparam logic KindFlush = 1'b1;

  // Up to two packed bytes produced by one input transaction.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;    // byte1 is valid
    logic       flush;  // final byte carries the last marker
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/nrle_if.sv =====
// ----------------------------------------------------------------------------
// nrle_if
// Valid/ready channels of the nibble run-length encoder.
// ----------------------------------------------------------------------------
interface nrle_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] data_nybble;

  modport source (output valid, output kind, output data_nybble, input ready);
  modport sink   (input valid, input kind, input data_nybble, output ready);
endinterface

interface nrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/nrle_front.sv =====
// ----------------------------------------------------------------------------
// nrle_front
// Tracks the current run and the held nybble, and turns each input
// transaction into zero, one or two packed bytes.
// ----------------------------------------------------------------------------
module nrle_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            kind_i,
  input  logic [3:0]      data_nybble_i,
  input  logic            full_i,
  output logic            ready_o,
  output logic            push_o,
  output nrle_pkg::entry_t entry_o
);
  import nrle_pkg::*;

  logic [3:0] run_value_q, run_value_d;
  logic [4:0] run_length_q, run_length_d;
  logic [3:0] held_nybble_q, held_nybble_d;
  logic       held_valid_q, held_valid_d;

  logic       is_flush;
  logic       end_run;
  logic       finishing;
  logic [3:0] s [3];
  logic [1:0] k;
  logic [2:0] cnt;
  logic [3:0] lst [5];
  logic       accept;
  logic [4:0] len_m2;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign is_flush = (kind_i == KindFlush);
  assign len_m2  = run_length_q - 5'd2;

  always_comb begin
    end_run   = is_flush || (data_nybble_i != run_value_q) ||
                (run_length_q >= 5'(MaxRunLen));
    finishing = end_run && (run_length_q != 5'd0);

    s[0] = 4'd0;
    s[1] = 4'd0;
    s[2] = 4'd0;
    k    = 2'd0;
    if (finishing) begin
      s[0] = run_value_q;
      k    = 2'd1;
      if (run_length_q > 5'd1) begin
        s[1] = run_value_q;
        k    = 2'd2;
        if (run_length_q == 5'd2 && !is_flush) begin
          k = 2'd3;  // non-final pair gets a zero marker
        end else if (run_length_q > 5'd2) begin
          s[2] = len_m2[3:0];
          k    = 2'd3;
        end
      end
    end

    cnt = {2'b00, held_valid_q} + {1'b0, k};
    // flush pads an odd nybble with zero; the list is already zero there
    if (is_flush && cnt[0]) begin
      cnt = cnt + 3'd1;
    end

    if (held_valid_q) begin
      lst[0] = held_nybble_q;
      lst[1] = s[0];
      lst[2] = s[1];
      lst[3] = s[2];
    end else begin
      lst[0] = s[0];
      lst[1] = s[1];
      lst[2] = s[2];
      lst[3] = 4'd0;
    end
    lst[4] = 4'd0;
  end

  always_comb begin
    run_value_d   = run_value_q;
    run_length_d  = run_length_q;
    held_nybble_d = held_nybble_q;
    held_valid_d  = held_valid_q;
    if (accept) begin
      if (is_flush) begin
        run_length_d = 5'd0;
      end else begin
        run_value_d  = data_nybble_i;
        run_length_d = finishing ? 5'd1 : run_length_q + 5'd1;
      end
      held_valid_d = cnt[0];
      unique case (cnt)
        3'd1:    held_nybble_d = lst[0];
        3'd3:    held_nybble_d = lst[2];
        3'd5:    held_nybble_d = lst[4];
        default: held_nybble_d = held_nybble_q;
      endcase
    end
  end

  always_comb begin
    entry_o.byte0 = {lst[1], lst[0]};
    entry_o.byte1 = {lst[3], lst[2]};
    entry_o.two   = (cnt[2:1] == 2'd2);
    entry_o.flush = is_flush;
    push_o        = accept && (cnt[2:1] != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q   <= 4'd0;
      run_length_q  <= 5'd0;
      held_nybble_q <= 4'd0;
      held_valid_q  <= 1'b0;
    end else begin
      run_value_q   <= run_value_d;
      run_length_q  <= run_length_d;
      held_nybble_q <= held_nybble_d;
      held_valid_q  <= held_valid_d;
    end
  end

endmodule

// ===== rtl/core/nrle_queue.sv =====
// ----------------------------------------------------------------------------
// nrle_queue
// Short register queue of byte entries between front and back.
// ----------------------------------------------------------------------------
module nrle_queue #(
  parameter int unsigned Depth = nrle_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  nrle_pkg::entry_t   entry_i,
  input  logic               pop_i,
  output nrle_pkg::entry_t   head_o,
  output nrle_pkg::q_status_t status_o
);
  import nrle_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [IdxW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/core/nrle_back.sv =====
// ----------------------------------------------------------------------------
// nrle_back
// Sends the bytes of the head queue entry, one per output transaction.
// ----------------------------------------------------------------------------
module nrle_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nrle_pkg::entry_t    head_i,
  input  nrle_pkg::q_status_t status_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_byte_o
);
  import nrle_pkg::*;

  logic sel_q, sel_d;
  logic fire;

  assign valid_o     = !status_i.empty;
  assign fire        = valid_o && ready_i;
  assign out_byte_o  = sel_q ? head_i.byte1 : head_i.byte0;
  assign last_byte_o = head_i.flush && (sel_q || !head_i.two);
  assign pop_o       = fire && (sel_q || !head_i.two);

  always_comb begin
    sel_d = sel_q;
    if (fire) begin
      sel_d = head_i.two && !sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// ===== rtl/core/nibble_run_length_encoder.sv =====
// ----------------------------------------------------------------------------
// nibble_run_length_encoder
// Run-length encodes a stream of nybbles and packs the code into bytes.
// ----------------------------------------------------------------------------
//  channel  dir  payload                 transaction
//  in_i     in   kind, data_nybble       valid && ready
//  out_o    out  out_byte, last_byte     valid && ready
//
//  One input transaction per cycle while the queue has room; the output
//  sends one byte per cycle while out_o.ready is high, so an item that ends
//  a run with two bytes takes two output transactions. Entries are queued
//  in registers before they are sent. Reset clears run state and empties
//  the queue. Input ready drops only when the entry queue is full.
// ----------------------------------------------------------------------------
`include "nibble_run_length_encoder_defines.svh"

module nibble_run_length_encoder #(
  parameter int unsigned QUEUE_DEPTH = nrle_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nrle_in_if.sink     in_i,
  nrle_out_if.source  out_o
);
  import nrle_pkg::*;

  entry_t    push_entry;
  entry_t    head;
  q_status_t q_stat;
  logic      push;
  logic      pop;

  nrle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .kind_i        (in_i.kind),
    .data_nybble_i (in_i.data_nybble),
    .full_i        (q_stat.full),
    .ready_o       (in_i.ready),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  nrle_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_stat)
  );

  nrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_stat),
    .pop_o       (pop),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .last_byte_o (out_o.last_byte)
  );

  `NRLE_ASSERT(a_no_overflow, !(push && q_stat.full), "push into full queue")
  `NRLE_ASSERT(a_no_underflow, !(pop && q_stat.empty), "pop from empty queue")
  `NRLE_ASSERT_NEXT(a_push_lands, push && !pop, !q_stat.empty, "pushed entry lost")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nibble run-length encoder: drives data and
// flush transactions with bursty gaps, stalls the byte channel, and checks
// every byte against a scoreboard that predicts the packed code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nrle_pkg::*;

  class rle_scoreboard;
    logic [3:0] run_val;
    logic [4:0] run_len;
    logic [3:0] held_nyb;
    bit         held_ok;
    logic [7:0] new_bytes[$];
    logic [7:0] byte_q[$];
    bit         last_q[$];
    int         errors;

    function new();
      run_val  = '0;
      run_len  = '0;
      held_nyb = '0;
      held_ok  = 1'b0;
      errors   = 0;
    endfunction

    function void add_nybble(logic [3:0] v);
      if (held_ok) begin
        new_bytes.insert(new_bytes.size(), {v, held_nyb});
        held_ok = 1'b0;
      end else begin
        held_nyb = v;
        held_ok  = 1'b1;
      end
    endfunction

    function void close_run(bit is_final);
      if (run_len > 0) begin
        add_nybble(run_val);
        if (run_len > 1) begin
          add_nybble(run_val);
          // a non-final pair carries an explicit zero count
          if (run_len == 2 && !is_final) add_nybble(4'h0);
          else if (run_len > 2) add_nybble(4'(run_len - 5'd2));
        end
      end
      run_len = '0;
    endfunction

    function void note_input(logic kind, logic [3:0] nyb);
      new_bytes.delete();
      if (kind == KindData) begin
        if (nyb != run_val || run_len >= MaxRunLen) close_run(1'b0);
        run_val = nyb;
        run_len = run_len + 5'd1;
      end else begin
        close_run(1'b1);
        if (held_ok) add_nybble(4'h0);
      end
      foreach (new_bytes[k]) begin
        byte_q.insert(byte_q.size(), new_bytes[k]);
        last_q.insert(last_q.size(), (kind == KindFlush && k == new_bytes.size() - 1));
      end
    endfunction

    function void check_output(logic [7:0] out_byte, logic last_byte);
      logic [7:0] exp_byte;
      bit         exp_last;
      if (byte_q.size() == 0) begin
        $error("unexpected byte: out_byte=%h last_byte=%b", out_byte, last_byte);
        errors++;
        return;
      end
      exp_byte = byte_q.pop_front();
      exp_last = last_q.pop_front();
      if (out_byte !== exp_byte) begin
        $error("out_byte: expected %h, actual %h", exp_byte, out_byte);
        errors++;
      end
      if (last_byte !== exp_last) begin
        $error("last_byte: expected %b, actual %b", exp_last, last_byte);
        errors++;
      end
    endfunction

    function int pending();
      return byte_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nrle_in_if  in_if ();
  nrle_out_if out_if ();

  nibble_run_length_encoder u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  rle_scoreboard sb = new();

  int burst_left = 0;
  int items_sent = 0;
  int rx_cycle   = 0;
  int rx_mode    = 0;
  int stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.kind        = KindData;
    in_if.data_nybble = 4'h0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // accepted transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_input(in_if.kind, in_if.data_nybble);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_output(out_if.out_byte,
                                                                out_if.last_byte);
  end

  // receiver: mode changes now and then; always ready, random, or long stalls
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready = 1'b1;
        1: out_if.ready = ($urandom_range(0, 3) != 0);
        default: begin
          out_if.ready = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
        end
      endcase
    end
  end

  task automatic send_item(logic kind, logic [3:0] nyb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid       = 1'b0;
        in_if.kind        = 1'($urandom);
        in_if.data_nybble = 4'($urandom);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid       = 1'b1;
    in_if.kind        = kind;
    in_if.data_nybble = nyb;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_run(logic [3:0] nyb, int len);
    repeat (len) send_item(KindData, nyb);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int         run_len;
    logic [3:0] run_nyb;
    bit         paused;

    paused = 1'b0;
    wait (rst_ni === 1'b1);

    // flush with nothing pending, first item equal to reset run value,
    // non-final pair, final pair, single values, run value kept over flush
    send_item(KindFlush, 4'h7);
    send_item(KindData, 4'h0);
    send_item(KindData, 4'h0);
    send_item(KindData, 4'hf);
    send_item(KindFlush, 4'h0);
    send_item(KindData, 4'hf);
    send_item(KindData, 4'hf);
    send_item(KindFlush, 4'hf);
    send_item(KindFlush, 4'h0);
    send_item(KindData, 4'h5);
    send_item(KindData, 4'ha);
    send_item(KindData, 4'ha);
    send_item(KindData, 4'ha);
    send_item(KindData, 4'h3);
    send_item(KindFlush, 4'h0);
    send_item(KindData, 4'h3);
    send_item(KindData, 4'hc);
    send_item(KindData, 4'h9);
    send_item(KindData, 4'h6);
    send_item(KindFlush, 4'h0);

    // random runs; long ones cross the forced split at the maximum length
    while (items_sent < 820) begin
      run_nyb = 4'($urandom);
      case ($urandom_range(0, 9))
        0, 1:    run_len = $urandom_range(15, 20);
        2:       run_len = $urandom_range(30, 36);
        default: run_len = $urandom_range(1, 4);
      endcase
      send_run(run_nyb, run_len);
      if ($urandom_range(0, 5) == 0) send_item(KindFlush, 4'($urandom));
      if ($urandom_range(0, 19) == 0) send_item(KindFlush, 4'($urandom));
      if (!paused && items_sent > 400) begin
        drain_results();
        paused = 1'b1;
      end
    end
    send_item(KindFlush, 4'($urandom));

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/nrle_pkg.sv
rtl/core/nrle_if.sv
rtl/core/nrle_front.sv
rtl/core/nrle_queue.sv
rtl/core/nrle_back.sv
rtl/core/nibble_run_length_encoder.sv
dv/tb.sv
